### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the bracket checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds at one edge, conseq must hold at the next one.
`define BBC_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, codes and the byte classifier of the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  typedef logic [1:0] kind_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } op_t;

  typedef enum logic [1:0] {
    FAIL_OK       = 2'd0,
    FAIL_CLOSE    = 2'd1,
    FAIL_UNCLOSED = 2'd2,
    FAIL_OVERFLOW = 2'd3
  } fail_t;

  localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
  localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
  localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
  localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

  localparam kind_t KIND_PAREN  = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY  = 2'd2;
  localparam kind_t KIND_ANGLE  = 2'd3;

  // One classified beat as it travels from the front to the back.
  typedef struct packed {
    op_t   op;
    kind_t kind;
    logic  last;
  } cmd_t;

  function automatic cmd_t classify(logic [7:0] b, logic has_char, logic last);
    cmd_t c;
    c.op   = OP_NONE;
    c.kind = KIND_PAREN;
    c.last = last;
    if (has_char) begin
      unique case (b)
        CH_OPEN_PAREN:   begin c.op = OP_PUSH; c.kind = KIND_PAREN;  end
        CH_OPEN_SQUARE:  begin c.op = OP_PUSH; c.kind = KIND_SQUARE; end
        CH_OPEN_CURLY:   begin c.op = OP_PUSH; c.kind = KIND_CURLY;  end
        CH_OPEN_ANGLE:   begin c.op = OP_PUSH; c.kind = KIND_ANGLE;  end
        CH_CLOSE_PAREN:  begin c.op = OP_POP;  c.kind = KIND_PAREN;  end
        CH_CLOSE_SQUARE: begin c.op = OP_POP;  c.kind = KIND_SQUARE; end
        CH_CLOSE_CURLY:  begin c.op = OP_POP;  c.kind = KIND_CURLY;  end
        CH_CLOSE_ANGLE:  begin c.op = OP_POP;  c.kind = KIND_ANGLE;  end
        default:         begin c.op = OP_NONE; end
      endcase
    end
    return c;
  endfunction

endpackage

### sv/bbc_in_if.sv
// ----------------------------------------------------------------------------
// bbc_in_if
// Valid/ready channel carrying one expression byte and its marks per beat.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       has_char;
  logic       last;

  modport source (output valid, output char_byte, output has_char, output last,
                  input ready);
  modport sink   (input valid, input char_byte, input has_char, input last,
                  output ready);
endinterface

### sv/bbc_out_if.sv
// ----------------------------------------------------------------------------
// bbc_out_if
// Valid/ready channel carrying one check result per beat.
// ----------------------------------------------------------------------------
interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [1:0] fail_code;

  modport source (output valid, output balanced, output fail_code, input ready);
  modport sink   (input valid, input balanced, input fail_code, output ready);
endinterface

### sv/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front
// Accepts input beats, classifies the byte and forwards beats that matter.
// ----------------------------------------------------------------------------
module bbc_front (
  bbc_in_if.sink        chars,
  input  logic          q_full,
  output logic          q_push,
  output bbc_pkg::cmd_t q_cmd
);
  import bbc_pkg::*;

  assign chars.ready = !q_full;
  assign q_cmd       = classify(chars.char_byte, chars.has_char, chars.last);

  // Ignored bytes and bare non-final marks are taken but never queued.
  assign q_push = chars.valid && !q_full && ((q_cmd.op != OP_NONE) || q_cmd.last);
endmodule

### sv/bbc_fifo.sv
// ----------------------------------------------------------------------------
// bbc_fifo
// Two-entry queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bbc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bbc_pkg::cmd_t head
);
  import bbc_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  `BBC_ASSERT(a_no_push_full, !(push && full), "push into a full queue")
  `BBC_ASSERT(a_no_pop_empty, !(pop && !head_valid), "pop from an empty queue")
  `BBC_ASSERT(a_fill_range, fill != 2'd3, "queue fill out of range")
endmodule

### sv/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back
// Runs pushes and pops on the bracket stack and registers the result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbc_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  bbc_pkg::cmd_t head,
  output logic          pop,
  bbc_out_if.source     result
);
  import bbc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Entry count-1 lives in top_kind; entries below it live in the memory.
  kind_t          mem [STACK_DEPTH];
  kind_t          rd_q;
  kind_t          top_kind;
  kind_t          top_kind_next;
  kind_t          byp_kind;
  logic           byp_valid;
  logic           byp_valid_next;
  kind_t          under_kind;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  count_op;
  fail_t          err;
  fail_t          err_op;
  fail_t          err_next;
  fail_t          code;
  logic           out_free;
  logic           push_do;
  logic           pop_do;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  cnt_m1;
  logic [CW-1:0]  cnt_m2;

  assign out_free   = !result.valid || result.ready;
  assign pop        = head_valid && (!head.last || out_free);
  assign under_kind = byp_valid ? byp_kind : rd_q;

  always_comb begin
    push_do  = 1'b0;
    pop_do   = 1'b0;
    err_op   = err;
    if (pop && (err == FAIL_OK)) begin
      unique case (head.op)
        OP_PUSH: begin
          if (count == CW'(STACK_DEPTH)) err_op = FAIL_OVERFLOW;
          else                            push_do = 1'b1;
        end
        OP_POP: begin
          if ((count == '0) || (top_kind != head.kind)) err_op = FAIL_CLOSE;
          else                                          pop_do = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_op      = count;
    top_kind_next = top_kind;
    if (push_do) begin
      count_op      = count + CW'(1);
      top_kind_next = head.kind;
    end else if (pop_do) begin
      count_op      = count - CW'(1);
      top_kind_next = under_kind;
    end
  end

  always_comb begin
    if (err_op != FAIL_OK)  code = err_op;
    else if (count_op != '0) code = FAIL_UNCLOSED;
    else                     code = FAIL_OK;
  end

  always_comb begin
    if (pop && head.last) begin
      count_next = '0;
      err_next   = FAIL_OK;
    end else begin
      count_next = count_op;
      err_next   = err_op;
    end
  end

  // The old top drops into the memory on a push; a read in the same cycle at
  // that address is served from the bypass register instead.
  assign cnt_m1         = count - CW'(1);
  assign cnt_m2         = count_next - CW'(2);
  assign wr_en          = push_do && (count != '0);
  assign wr_addr        = cnt_m1[AW-1:0];
  assign rd_addr        = cnt_m2[AW-1:0];
  assign byp_valid_next = wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_kind;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    top_kind <= top_kind_next;
    byp_kind <= top_kind;
    if (out_free && pop && head.last) begin
      result.balanced  <= (code == FAIL_OK);
      result.fail_code <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      err          <= FAIL_OK;
      byp_valid    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      count     <= count_next;
      err       <= err_next;
      byp_valid <= byp_valid_next;
      if (out_free) result.valid <= pop && head.last;
    end
  end

  `BBC_ASSERT(a_count_bound, count <= CW'(STACK_DEPTH), "stack count above depth")
  `BBC_ASSERT(a_err_code, err != FAIL_UNCLOSED, "unclosed code held as sticky error")
  `BBC_ASSERT_NEXT(a_end_clears, pop && head.last, (count == '0) && (err == FAIL_OK),
                   "state not cleared after end mark")
  `BBC_ASSERT_NEXT(a_err_freezes, (err != FAIL_OK) && !(pop && head.last),
                   $stable(count), "stack moved after an error")
endmodule

### sv/bracket_balance_checker_top.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Checks nesting of ( [ { < brackets over a byte stream, one result per
// expression.
// ----------------------------------------------------------------------------
//
//   Channel   Role     Payload                          Beat
//   chars     sink     char_byte[7:0], has_char, last   one byte or end mark
//   result    source   balanced, fail_code[1:0]         one per end mark
//
// Throughput is one input beat per cycle while the command queue is not full.
// The stack top is held in a register and the entry below it is prefetched
// from the stack memory every cycle, so a push or a pop never waits on a
// memory read. An accepted end mark passes through the command queue and
// then the result register on its way to its result beat.
// Reset clears the stack count, the sticky error and all valid state; the
// stack memory is not cleared, since only written entries are ever read.
// A stalled result holds the back end only on end marks; the two-entry queue
// lets the front keep taking beats meanwhile until it fills.
//
// The front classifies each byte into a push, a pop or nothing and drops beats
// that have no effect. The back keeps the stack in a memory of STACK_DEPTH
// two-bit kinds, tracks the first error of the expression, and on the end
// mark loads the result register and clears its state for the next
// expression. Once an error is recorded, later bytes of the same expression
// leave the stack untouched. A sticky error is reported ahead of an unclosed
// stack.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    chars,
  bbc_out_if.source result
);
  import bbc_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  // Front end: handshake on the input channel and byte classification.
  bbc_front u_front (
    .chars  (chars),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  // Short queue that lets the front and the back stall independently.
  bbc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back end: stack operations, error tracking and the result register.
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .result     (result)
  );
endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bracket balance checker. A short table of
// directed beats covers the empty expression, every bracket kind, wrong and
// stray closes, unclosed stacks, first-error-wins and stack overflow. Random
// expressions follow, mostly well nested with noise bytes mixed in, some
// deliberately broken. Every result beat is compared with the verdict of a
// bracket-stack predictor kept inside the bench, or of the table row where it
// fixes the verdict, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int STACK_DEPTH  = 64;
  localparam int RANDOM_BEATS = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int PLAN_ROWS    = 26;

  // Expected content of one result beat.
  typedef struct packed {
    logic  balanced;
    fail_t code;
  } verdict_t;

  // One input beat as the bench drives it.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } beat_t;

  // One row of the directed table. A row is repeated reps times. Where typed
  // is set, the verdict of an end mark is taken from the row itself instead
  // of from the predictor.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
    logic [6:0] reps;
    logic       typed;
    logic       balanced;
    fail_t      code;
  } plan_row_t;

  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // An empty expression straight after reset is balanced.
    '{8'h00,           1'b0, 1'b1, 7'd1,  1'b1, 1'b1, FAIL_OK},
    // A beat with neither a byte nor an end mark does nothing at all.
    '{8'hFF,           1'b0, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    // Byte and end mark on the same beat: the close is taken, then the report.
    '{CH_OPEN_PAREN,   1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_CLOSE_PAREN,  1'b1, 1'b1, 7'd1,  1'b1, 1'b1, FAIL_OK},
    // Close of the wrong kind.
    '{CH_OPEN_SQUARE,  1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_CLOSE_CURLY,  1'b1, 1'b1, 7'd1,  1'b1, 1'b0, FAIL_CLOSE},
    // Close on an empty stack.
    '{CH_CLOSE_ANGLE,  1'b1, 1'b1, 7'd1,  1'b1, 1'b0, FAIL_CLOSE},
    // Two opens left unclosed; the extreme bytes in between are ignored and
    // the byte that rides on the bare end mark does not count.
    '{CH_OPEN_CURLY,   1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_OPEN_ANGLE,   1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{8'h00,           1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{8'hFF,           1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_CLOSE_SQUARE, 1'b0, 1'b1, 7'd1,  1'b1, 1'b0, FAIL_UNCLOSED},
    // The first error wins: the open and close after it are not looked at.
    '{CH_CLOSE_SQUARE, 1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_OPEN_PAREN,   1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_CLOSE_PAREN,  1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{8'h00,           1'b0, 1'b1, 7'd1,  1'b1, 1'b0, FAIL_CLOSE},
    // Properly nested with a noise byte inside, checked by the predictor.
    '{CH_OPEN_ANGLE,   1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_OPEN_SQUARE,  1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_CLOSE_SQUARE, 1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{8'hA5,           1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_CLOSE_ANGLE,  1'b1, 1'b1, 7'd1,  1'b0, 1'b0, FAIL_OK},
    // Fill the stack to the brim, then push once more for an overflow.
    '{CH_OPEN_CURLY,   1'b1, 1'b0, 7'd64, 1'b0, 1'b0, FAIL_OK},
    '{CH_OPEN_PAREN,   1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{CH_CLOSE_CURLY,  1'b1, 1'b0, 7'd1,  1'b0, 1'b0, FAIL_OK},
    '{8'h00,           1'b0, 1'b1, 7'd1,  1'b1, 1'b0, FAIL_OVERFLOW},
    // The state was cleared by the report: an ignored byte with the end mark.
    '{8'h80,           1'b1, 1'b1, 7'd1,  1'b1, 1'b1, FAIL_OK}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbc_in_if  chars_if ();
  bbc_out_if result_if ();

  bracket_balance_checker_top #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if)
  );

  always #2 clk = ~clk;

  // Sideband that travels with each driven beat, so the scoreboard knows
  // whether the directed table fixed the verdict of this beat.
  logic     typed_now = 1'b0;
  verdict_t typed_verdict = '0;

  // Flow control between the stimulus and the result sink.
  bit hold_req   = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left  = 0;
  bit rx_quiet   = 1'b0;
  bit tx_quiet   = 1'b0;

  int       mismatches = 0;
  verdict_t pending_verdicts [$];
  beat_t    expr_beats [$];

  // Predictor state: the open bracket kinds, how many are held, and the
  // sticky failure of the expression in progress.
  kind_t open_kinds [STACK_DEPTH];
  int    open_count = 0;
  fail_t sticky_fail = FAIL_OK;

  function automatic logic [7:0] open_char(kind_t k);
    case (k)
      KIND_PAREN:  return CH_OPEN_PAREN;
      KIND_SQUARE: return CH_OPEN_SQUARE;
      KIND_CURLY:  return CH_OPEN_CURLY;
      default:     return CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] close_char(kind_t k);
    case (k)
      KIND_PAREN:  return CH_CLOSE_PAREN;
      KIND_SQUARE: return CH_CLOSE_SQUARE;
      KIND_CURLY:  return CH_CLOSE_CURLY;
      default:     return CH_CLOSE_ANGLE;
    endcase
  endfunction

  // Advances the bracket stack by one accepted beat. On an end mark it sets
  // reports and returns the verdict, then clears the stack for the next
  // expression.
  function automatic void track_beat(input beat_t bt, output bit reports,
                                     output verdict_t v);
    bit    is_open;
    bit    is_close;
    kind_t k;
    int    i;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = KIND_PAREN;
    reports  = bt.last;
    v.balanced = 1'b1;
    v.code     = FAIL_OK;
    // Once an error is recorded, the rest of the expression is not looked at.
    if (bt.has_char && sticky_fail == FAIL_OK) begin
      for (i = 0; i < 4; i++) begin
        if (bt.ch == open_char(kind_t'(i))) begin
          is_open = 1'b1;
          k = kind_t'(i);
        end
        if (bt.ch == close_char(kind_t'(i))) begin
          is_close = 1'b1;
          k = kind_t'(i);
        end
      end
      if (is_open) begin
        if (open_count >= STACK_DEPTH) begin
          sticky_fail = FAIL_OVERFLOW;
        end else begin
          open_kinds[open_count] = k;
          open_count++;
        end
      end else if (is_close) begin
        if (open_count == 0 || open_kinds[open_count - 1] != k) begin
          sticky_fail = FAIL_CLOSE;
        end else begin
          open_count--;
        end
      end
    end
    if (bt.last) begin
      // A sticky error outranks an unclosed stack.
      if (sticky_fail != FAIL_OK) begin
        v.code = sticky_fail;
      end else if (open_count != 0) begin
        v.code = FAIL_UNCLOSED;
      end
      v.balanced  = (v.code == FAIL_OK);
      open_count  = 0;
      sticky_fail = FAIL_OK;
    end
  endfunction

  // Offers one beat and returns at the edge where it is taken. Random idle
  // cycles come first unless the stimulus is in its quiet stretch. Each pass
  // through here makes exactly one assignment to valid per time step.
  task automatic drive_beat(input beat_t bt, input logic typed, input verdict_t tv);
    while (!tx_quiet && $urandom_range(99) < 20) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_byte <= bt.ch;
    chars_if.has_char  <= bt.has_char;
    chars_if.last      <= bt.last;
    typed_now          <= typed;
    typed_verdict      <= tv;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
  endtask

  task automatic add_char(input logic [7:0] ch);
    beat_t bt;
    bt.ch       = ch;
    bt.has_char = 1'b1;
    bt.last     = 1'b0;
    expr_beats.push_back(bt);
  endtask

  // Builds one random expression into expr_beats. Most are well nested with
  // noise bytes mixed in; the rest carry a wrong-kind close, a stray close
  // up front, an unclosed tail, or run the stack up to and past its depth.
  task automatic build_expression();
    kind_t opened [$];
    kind_t k;
    beat_t bt;
    int    style;
    int    steps;
    int    target;
    int    i;
    int    r;
    bit    bent;
    expr_beats.delete();
    style = $urandom_range(99);
    bent  = 1'b0;
    if (style < 3) begin
      // Nothing but the end mark.
    end else if (style < 8) begin
      // Deep nesting: near full, exactly full, or overflowing.
      target = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2);
      for (i = 0; i < target; i++) begin
        k = kind_t'($urandom_range(3));
        opened.push_back(k);
        add_char(open_char(k));
      end
      while (opened.size() > 0) add_char(close_char(opened.pop_back()));
    end else begin
      if (style >= 80 && style < 88) begin
        add_char(close_char(kind_t'($urandom_range(3))));
      end
      steps = $urandom_range(1, 18);
      for (i = 0; i < steps; i++) begin
        r = $urandom_range(99);
        if (r < 40 && opened.size() < 16) begin
          k = kind_t'($urandom_range(3));
          opened.push_back(k);
          add_char(open_char(k));
        end else if (r < 75 && opened.size() > 0) begin
          k = opened.pop_back();
          if (style >= 72 && style < 80 && !bent && $urandom_range(1) == 1) begin
            k    = k ^ kind_t'($urandom_range(1, 3));
            bent = 1'b1;
          end
          add_char(close_char(k));
        end else begin
          add_char(8'($urandom_range(255)));
        end
      end
      if (style >= 88 && style < 96) begin
        if (opened.size() == 0) add_char(open_char(kind_t'($urandom_range(3))));
      end else begin
        while (opened.size() > 0) add_char(close_char(opened.pop_back()));
      end
    end
    // The end mark either rides on the last byte or comes bare.
    if (expr_beats.size() > 0 && $urandom_range(1) == 1) begin
      bt = expr_beats.pop_back();
      bt.last = 1'b1;
      expr_beats.push_back(bt);
    end else begin
      bt.ch       = 8'($urandom_range(255));
      bt.has_char = 1'b0;
      bt.last     = 1'b1;
      expr_beats.push_back(bt);
    end
  endtask

  // Result sink. Ready drops in about one cycle of five, never during the
  // quiet stretch, and once for a long hold-off that backs the block up
  // into its input while the stimulus keeps offering beats.
  always @(posedge clk) begin : result_sink
    if (rst) begin
      result_if.ready <= 1'b0;
      hold_left       <= 0;
    end else if (hold_left != 0) begin
      result_if.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      result_if.ready <= 1'b0;
      hold_taken      <= 1'b1;
      hold_left       <= HOLD_CYCLES;
    end else begin
      result_if.ready <= rx_quiet || ($urandom_range(99) >= 20);
    end
  end

  // Scoreboard. Both channels are sampled at the same edge: an accepted input
  // beat goes through the predictor first, then an accepted result beat is
  // compared field by field with the oldest pending verdict.
  always @(posedge clk) begin : scoreboard
    verdict_t v;
    verdict_t want;
    bit       reports;
    if (!rst) begin
      if (chars_if.valid && chars_if.ready) begin
        track_beat(beat_t'({chars_if.char_byte, chars_if.has_char, chars_if.last}),
                   reports, v);
        if (reports) pending_verdicts.push_back(typed_now ? typed_verdict : v);
      end
      if (result_if.valid && result_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, balanced=%0b fail_code=%0d",
                   $time, result_if.balanced, result_if.fail_code);
        end else begin
          want = pending_verdicts.pop_front();
          if (result_if.balanced !== want.balanced) begin
            mismatches++;
            $display("%0t: balanced expected %0b actual %0b",
                     $time, want.balanced, result_if.balanced);
          end
          if (result_if.fail_code !== want.code) begin
            mismatches++;
            $display("%0t: fail_code expected %0d actual %0d",
                     $time, want.code, result_if.fail_code);
          end
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random expressions, then the
  // drain and the final verdict.
  initial begin : stimulus
    beat_t    bt;
    verdict_t tv;
    int       row;
    int       rep;
    int       sent;
    int       i;
    chars_if.valid     = 1'b0;
    chars_if.char_byte = 8'h00;
    chars_if.has_char  = 1'b0;
    chars_if.last      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (row = 0; row < PLAN_ROWS; row++) begin
      bt.ch       = DIRECTED_PLAN[row].ch;
      bt.has_char = DIRECTED_PLAN[row].has_char;
      bt.last     = DIRECTED_PLAN[row].last;
      tv.balanced = DIRECTED_PLAN[row].balanced;
      tv.code     = DIRECTED_PLAN[row].code;
      for (rep = 0; rep < int'(DIRECTED_PLAN[row].reps); rep++) begin
        drive_beat(bt, DIRECTED_PLAN[row].typed, tv);
      end
    end

    // Random part. Ignored beats with neither a byte nor an end mark are
    // sprinkled in but do not count toward the total.
    sent = 0;
    tv   = '0;
    while (sent < RANDOM_BEATS) begin
      build_expression();
      for (i = 0; i < expr_beats.size(); i++) begin
        if ($urandom_range(99) < 4) begin
          bt.ch       = 8'($urandom_range(255));
          bt.has_char = 1'b0;
          bt.last     = 1'b0;
          drive_beat(bt, 1'b0, tv);
        end
        drive_beat(expr_beats[i], 1'b0, tv);
        sent++;
        // A long stretch in which neither side idles.
        tx_quiet = (sent >= 700 && sent < 1000);
        rx_quiet <= (sent >= 700 && sent < 1000);
        if (sent == 300) hold_req <= 1'b1;
        if (sent == 1200) begin
          // Let the block run dry before going on.
          chars_if.valid <= 1'b0;
          @(posedge clk);
          while (pending_verdicts.size() != 0) @(posedge clk);
        end
      end
    end

    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    // Idle clocks after the drain catch any stray result beat behind the last one.
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a run that hangs on a handshake ends here.
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

### bracket_balance_checker_top.f
+incdir+sv
sv/bbc_pkg.sv
sv/bbc_in_if.sv
sv/bbc_out_if.sv
sv/bbc_front.sv
sv/bbc_fifo.sv
sv/bbc_back.sv
sv/bracket_balance_checker_top.sv
tb/tb_top.sv
